[rtl/bfha_pkg.sv]
package bfha_pkg;

   typedef enum logic [4:0] {
      S_IDLE,
      S_A_SLOT,
      S_A_FIT_RD,
      S_A_FIT_EV,
      S_A_FIT_DONE,
      S_A_TOP_RD,
      S_A_TOP_EV,
      S_A_COMMIT,
      S_F_FIND_RD,
      S_F_FIND_EV,
      S_F_POS_RD,
      S_F_POS_EV,
      S_F_MERGE,
      S_F_LAST_RD,
      S_F_LAST_EV,
      S_F_COMMIT,
      S_DEL_RD,
      S_DEL_WR,
      S_INS_RD,
      S_INS_WR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [15:0] start;
      logic [15:0] len;
   } ext_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic CSR_BASE  = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   localparam logic [17:0] TAG_BYTES   = 18'd2;
   localparam logic [17:0] SPLIT_SLACK = 18'd6;

   localparam logic [15:0] BASE_RESET  = 16'd256;
   localparam logic [15:0] LIMIT_RESET = 16'd65535;

endpackage

[rtl/bfha_ram.sv]
module bfha_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             we,
   input  logic [$clog2(DEPTH)-1:0]         waddr,
   input  logic [WIDTH-1:0]                 wdata,
   input  logic [$clog2(DEPTH)-1:0]         raddr,
   output logic [WIDTH-1:0]                 rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[rtl/best_fit_heap_allocator.sv]
// Best-fit heap allocator. Each request (tuser = 0 allocate, 1 free) yields one
// response. Free extents sit address-sorted in a FREE_SLOTS-entry RAM, live
// blocks in a LIVE_SLOTS-entry RAM with valid flip-flops. A small sequencer
// walks these RAMs one entry per access, each read setting the address and then
// comparing the data; the allocate's free-slot search steps through the valid
// flip-flops one per cycle. The live-table scan and the extent shifts on insert
// and remove are what make a free or an allocate run long. The block takes no
// request until the response has been taken.
// Writing heap_base empties both tables and sets the heap top at once.
module best_fit_heap_allocator #(
   parameter int FREE_SLOTS = 16,
   parameter int LIVE_SLOTS = 32,
   parameter int MIN_BLOCK  = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] req_size, [31:16] addr
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] user_addr, [31:16] block_size, [47:32] heap_top
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import bfha_pkg::*;

   localparam int FW = (FREE_SLOTS > 1) ? $clog2(FREE_SLOTS) : 1;
   localparam int CW = $clog2(FREE_SLOTS + 1);
   localparam int LW = (LIVE_SLOTS > 1) ? $clog2(LIVE_SLOTS) : 1;
   localparam logic [15:0]   MIN_SZ    = 16'(MIN_BLOCK);
   localparam logic [LW-1:0] LIVE_LAST = LW'(LIVE_SLOTS - 1);
   localparam logic [CW-1:0] FREE_MAX  = CW'(FREE_SLOTS);

   state_type state_ff, state_in, ret_ff, ret_in;
   logic [15:0] base_ff, base_in, limit_ff, limit_in, break_ff, break_in;
   logic [CW-1:0] count_ff, count_in, i_ff, i_in, k_ff, k_in, best_ff, best_in;
   logic [LIVE_SLOTS-1:0] valid_ff, valid_in;
   logic [LW-1:0] j_ff, j_in;
   logic found_ff, found_in, nxt_ok_ff, nxt_ok_in;
   logic [15:0] sz_ff, sz_in, addr_ff, addr_in, s_ff, s_in, l_ff, l_in;
   ext_type best_e_ff, best_e_in, prv_ff, prv_in, nxt_ff, nxt_in, ins_ff, ins_in;
   logic [1:0] status_ff, status_in;
   logic [15:0] uaddr_ff, uaddr_in, bsize_ff, bsize_in;

   logic          fr_we, lv_we;
   logic [FW-1:0] fr_waddr, fr_raddr;
   logic [LW-1:0] lv_waddr, lv_raddr;
   ext_type       fr_wdata, lv_wdata, fr_ext, lv_ext;
   logic [31:0]   fr_rdata, lv_rdata;

   logic          cfg_wr;
   logic [CW-1:0] cnt_m1, k_p1, k_m1;
   logic [17:0]   fr_end, newend, sz_slack, e_w, prv_end, grow_len, best_rem;
   logic          mp, mn;

   bfha_ram #(.WIDTH($bits(ext_type)), .DEPTH(FREE_SLOTS)) u_free_ram (
      .clock (clock),
      .we    (fr_we),
      .waddr (fr_waddr),
      .wdata (fr_wdata),
      .raddr (fr_raddr),
      .rdata (fr_rdata)
   );

   bfha_ram #(.WIDTH($bits(ext_type)), .DEPTH(LIVE_SLOTS)) u_live_ram (
      .clock (clock),
      .we    (lv_we),
      .waddr (lv_waddr),
      .wdata (lv_wdata),
      .raddr (lv_raddr),
      .rdata (lv_rdata)
   );

   assign fr_ext = ext_type'(fr_rdata);
   assign lv_ext = ext_type'(lv_rdata);

   assign cfg_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = {16'd0, (csr_paddr[2] == CSR_LIMIT) ? limit_ff : base_ff};

   assign cnt_m1 = count_ff - CW'(1);
   assign k_p1   = k_ff + CW'(1);
   assign k_m1   = k_ff - CW'(1);

   assign fr_end   = {2'b0, fr_ext.start} + {2'b0, fr_ext.len} + TAG_BYTES;
   assign newend   = {2'b0, break_ff} + {2'b0, sz_ff} + TAG_BYTES;
   assign sz_slack = {2'b0, sz_ff} + SPLIT_SLACK;
   assign e_w      = {2'b0, s_ff} + {2'b0, l_ff} + TAG_BYTES;
   assign prv_end  = {2'b0, prv_ff.start} + {2'b0, prv_ff.len} + TAG_BYTES;
   assign grow_len = {2'b0, fr_ext.len} + {2'b0, sz_ff} + TAG_BYTES;
   assign best_rem = {2'b0, best_e_ff.len} - {2'b0, sz_ff} - TAG_BYTES;
   assign mp = (i_ff != '0) && (prv_end == {2'b0, s_ff});
   assign mn = nxt_ok_ff && (nxt_ff.start == e_w[15:0]) && (e_w[17:16] == 2'b0);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {break_ff, bsize_ff, uaddr_ff};
   assign rsp_tuser  = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         base_ff  <= BASE_RESET;
         limit_ff <= LIMIT_RESET;
         break_ff <= BASE_RESET;
         count_ff <= '0;
         valid_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         base_ff  <= base_in;
         limit_ff <= limit_in;
         break_ff <= break_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      i_ff      <= i_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      best_ff   <= best_in;
      found_ff  <= found_in;
      nxt_ok_ff <= nxt_ok_in;
      sz_ff     <= sz_in;
      addr_ff   <= addr_in;
      s_ff      <= s_in;
      l_ff      <= l_in;
      best_e_ff <= best_e_in;
      prv_ff    <= prv_in;
      nxt_ff    <= nxt_in;
      ins_ff    <= ins_in;
      status_ff <= status_in;
      uaddr_ff  <= uaddr_in;
      bsize_ff  <= bsize_in;
   end

   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      base_in   = base_ff;
      limit_in  = limit_ff;
      break_in  = break_ff;
      count_in  = count_ff;
      valid_in  = valid_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      best_in   = best_ff;
      found_in  = found_ff;
      nxt_ok_in = nxt_ok_ff;
      sz_in     = sz_ff;
      addr_in   = addr_ff;
      s_in      = s_ff;
      l_in      = l_ff;
      best_e_in = best_e_ff;
      prv_in    = prv_ff;
      nxt_in    = nxt_ff;
      ins_in    = ins_ff;
      status_in = status_ff;
      uaddr_in  = uaddr_ff;
      bsize_in  = bsize_ff;
      fr_we     = 1'b0;
      fr_waddr  = '0;
      fr_wdata  = '0;
      fr_raddr  = '0;
      lv_we     = 1'b0;
      lv_waddr  = '0;
      lv_wdata  = '0;
      lv_raddr  = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               sz_in    = (req_tdata[15:0] < MIN_SZ) ? MIN_SZ : req_tdata[15:0];
               addr_in  = req_tdata[31:16];
               j_in     = '0;
               uaddr_in = '0;
               bsize_in = '0;
               state_in = (req_tuser == CMD_FREE) ? S_F_FIND_RD : S_A_SLOT;
            end
         end

         // first free live slot, one valid bit a cycle
         S_A_SLOT: begin
            if (!valid_ff[j_ff]) begin
               i_in     = '0;
               found_in = 1'b0;
               state_in = S_A_FIT_RD;
            end else if (j_ff == LIVE_LAST) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               j_in = j_ff + LW'(1);
            end
         end

         S_A_FIT_RD: begin
            fr_raddr = i_ff[FW-1:0];
            state_in = (i_ff < count_ff) ? S_A_FIT_EV : S_A_FIT_DONE;
         end

         S_A_FIT_EV: begin
            if (fr_ext.len >= sz_ff && (!found_ff || fr_ext.len < best_e_ff.len)) begin
               found_in  = 1'b1;
               best_in   = i_ff;
               best_e_in = fr_ext;
            end
            i_in     = i_ff + CW'(1);
            state_in = S_A_FIT_RD;
         end

         S_A_FIT_DONE: begin
            if (found_ff) begin
               s_in = best_e_ff.start;
               if ({2'b0, best_e_ff.len} > sz_slack) begin
                  // split: tail stays in the same slot
                  fr_we          = 1'b1;
                  fr_waddr       = best_ff[FW-1:0];
                  fr_wdata.start = 16'({2'b0, best_e_ff.start} + TAG_BYTES + {2'b0, sz_ff});
                  fr_wdata.len   = best_rem[15:0];
                  l_in           = sz_ff;
                  state_in       = S_A_COMMIT;
               end else begin
                  l_in     = best_e_ff.len;
                  k_in     = best_ff;
                  ret_in   = S_A_COMMIT;
                  state_in = S_DEL_RD;
               end
            end else if (newend >= {2'b0, limit_ff}) begin
               status_in = ST_NOSPACE;
               state_in  = S_RESP;
            end else if (count_ff != '0) begin
               state_in = S_A_TOP_RD;
            end else begin
               s_in     = break_ff;
               l_in     = sz_ff;
               break_in = newend[15:0];
               state_in = S_A_COMMIT;
            end
         end

         S_A_TOP_RD: begin
            fr_raddr = cnt_m1[FW-1:0];
            state_in = S_A_TOP_EV;
         end

         S_A_TOP_EV: begin
            if (fr_end == {2'b0, break_ff}) begin
               // grow the top extent, then carve from it
               s_in = fr_ext.start;
               if (grow_len > sz_slack) begin
                  fr_we          = 1'b1;
                  fr_waddr       = cnt_m1[FW-1:0];
                  fr_wdata.start = 16'({2'b0, fr_ext.start} + TAG_BYTES + {2'b0, sz_ff});
                  fr_wdata.len   = fr_ext.len;
                  l_in           = sz_ff;
               end else begin
                  count_in = cnt_m1;
                  l_in     = grow_len[15:0];
               end
            end else begin
               s_in = break_ff;
               l_in = sz_ff;
            end
            break_in = newend[15:0];
            state_in = S_A_COMMIT;
         end

         S_A_COMMIT: begin
            lv_we          = 1'b1;
            lv_waddr       = j_ff;
            lv_wdata.start = s_ff;
            lv_wdata.len   = l_ff;
            valid_in[j_ff] = 1'b1;
            status_in      = ST_OK;
            uaddr_in       = 16'({2'b0, s_ff} + TAG_BYTES);
            bsize_in       = l_ff;
            state_in       = S_RESP;
         end

         S_F_FIND_RD: begin
            lv_raddr = j_ff;
            if (valid_ff[j_ff]) begin
               state_in = S_F_FIND_EV;
            end else if (j_ff == LIVE_LAST) begin
               status_in = ST_UNKNOWN;
               state_in  = S_RESP;
            end else begin
               j_in = j_ff + LW'(1);
            end
         end

         S_F_FIND_EV: begin
            if ({2'b0, lv_ext.start} + TAG_BYTES == {2'b0, addr_ff}) begin
               s_in     = lv_ext.start;
               l_in     = lv_ext.len;
               i_in     = '0;
               state_in = S_F_POS_RD;
            end else if (j_ff == LIVE_LAST) begin
               status_in = ST_UNKNOWN;
               state_in  = S_RESP;
            end else begin
               j_in     = j_ff + LW'(1);
               state_in = S_F_FIND_RD;
            end
         end

         S_F_POS_RD: begin
            fr_raddr = i_ff[FW-1:0];
            if (i_ff < count_ff) begin
               state_in = S_F_POS_EV;
            end else begin
               nxt_ok_in = 1'b0;
               state_in  = S_F_MERGE;
            end
         end

         S_F_POS_EV: begin
            if (fr_ext.start < s_ff) begin
               prv_in   = fr_ext;
               i_in     = i_ff + CW'(1);
               state_in = S_F_POS_RD;
            end else begin
               nxt_in    = fr_ext;
               nxt_ok_in = 1'b1;
               state_in  = S_F_MERGE;
            end
         end

         S_F_MERGE: begin
            if (e_w == {2'b0, break_ff} && !mn) begin
               if (mp) begin
                  break_in = prv_ff.start;
                  k_in     = i_ff - CW'(1);
                  ret_in   = S_F_COMMIT;
                  state_in = S_DEL_RD;
               end else begin
                  break_in = s_ff;
                  state_in = S_F_COMMIT;
               end
            end else if (mp && mn) begin
               fr_we          = 1'b1;
               fr_waddr       = FW'(i_ff - CW'(1));
               fr_wdata.start = prv_ff.start;
               fr_wdata.len   = 16'({2'b0, prv_ff.len} + {2'b0, l_ff} + TAG_BYTES
                                    + {2'b0, nxt_ff.len} + TAG_BYTES);
               k_in           = i_ff;
               ret_in         = S_F_LAST_RD;
               state_in       = S_DEL_RD;
            end else if (mp) begin
               fr_we          = 1'b1;
               fr_waddr       = FW'(i_ff - CW'(1));
               fr_wdata.start = prv_ff.start;
               fr_wdata.len   = 16'({2'b0, prv_ff.len} + {2'b0, l_ff} + TAG_BYTES);
               state_in       = S_F_LAST_RD;
            end else if (mn) begin
               fr_we          = 1'b1;
               fr_waddr       = i_ff[FW-1:0];
               fr_wdata.start = s_ff;
               fr_wdata.len   = 16'({2'b0, nxt_ff.len} + {2'b0, l_ff} + TAG_BYTES);
               state_in       = S_F_LAST_RD;
            end else if (count_ff >= FREE_MAX) begin
               status_in = ST_FULL;
               state_in  = S_RESP;
            end else begin
               ins_in.start = s_ff;
               ins_in.len   = l_ff;
               k_in         = count_ff;
               ret_in       = S_F_LAST_RD;
               state_in     = S_INS_RD;
            end
         end

         S_F_LAST_RD: begin
            fr_raddr = cnt_m1[FW-1:0];
            state_in = (count_ff != '0) ? S_F_LAST_EV : S_F_COMMIT;
         end

         // drop the top extent when it reaches the heap top
         S_F_LAST_EV: begin
            if (fr_end == {2'b0, break_ff}) begin
               break_in = fr_ext.start;
               count_in = cnt_m1;
            end
            state_in = S_F_COMMIT;
         end

         S_F_COMMIT: begin
            valid_in[j_ff] = 1'b0;
            status_in      = ST_OK;
            bsize_in       = l_ff;
            state_in       = S_RESP;
         end

         // remove entry k: move the later entries down one at a time
         S_DEL_RD: begin
            fr_raddr = k_p1[FW-1:0];
            if (k_p1 < count_ff) begin
               state_in = S_DEL_WR;
            end else begin
               count_in = cnt_m1;
               state_in = ret_ff;
            end
         end

         S_DEL_WR: begin
            fr_we    = 1'b1;
            fr_waddr = k_ff[FW-1:0];
            fr_wdata = fr_ext;
            k_in     = k_p1;
            state_in = S_DEL_RD;
         end

         // insert at position i: move entries up from the end
         S_INS_RD: begin
            fr_raddr = k_m1[FW-1:0];
            if (k_ff > i_ff) begin
               state_in = S_INS_WR;
            end else begin
               fr_we    = 1'b1;
               fr_waddr = i_ff[FW-1:0];
               fr_wdata = ins_ff;
               count_in = count_ff + CW'(1);
               state_in = ret_ff;
            end
         end

         S_INS_WR: begin
            fr_we    = 1'b1;
            fr_waddr = k_ff[FW-1:0];
            fr_wdata = fr_ext;
            k_in     = k_m1;
            state_in = S_INS_RD;
         end

         S_RESP: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cfg_wr) begin
         if (csr_paddr[2] == CSR_BASE) begin
            base_in  = csr_pwdata[15:0];
            break_in = csr_pwdata[15:0];
            count_in = '0;
            valid_in = '0;
         end else begin
            limit_in = csr_pwdata[15:0];
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FREE_MAX)
      else $error("free extent count beyond table size");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while another is in progress");

   a_grant_below_top: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && status_ff == ST_OK && uaddr_ff != '0)
         |-> ({2'b0, uaddr_ff} + {2'b0, bsize_ff} <= {2'b0, break_ff}))
      else $error("granted block runs past heap top");

   a_base_reinit: assert property (@(posedge clock) disable iff (reset)
      (cfg_wr && csr_paddr[2] == CSR_BASE)
         |=> (count_ff == '0 && valid_ff == '0 && break_ff == $past(csr_pwdata[15:0])))
      else $error("heap base write did not reinitialise");
`endif

endmodule
